### design/fafe_pkg.sv
package fafe_pkg;

   // Request and record field widths
   localparam int ACTION_W = 1;
   localparam int PAGE_W   = 12;
   localparam int OWNER_W  = 8;
   localparam int STACK_W  = 21;
   localparam int FRAME_W  = 5;
   localparam int SWAP_W   = 20;
   localparam int FREE_W   = 6;

   // Request action codes
   localparam logic [ACTION_W-1:0] ACT_ALLOC   = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 1'b1;

   // Stack offset that marks a page without a stack swap slot
   localparam logic [STACK_W-1:0] NO_STACK = '1;

   // One frame record as held in the record memory
   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [OWNER_W-1:0] owner;
      logic [STACK_W-1:0] stack;
   } rec_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_READ,
      ST_LATCH,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

### design/frame_allocator_fifo_evict.sv
// Frame allocator with first-in first-out replacement. An allocate request
// takes the lowest free frame; a free-frame search walks the valid bits one
// frame per cycle. With every frame in use, the frame under the round-robin
// pointer is evicted and a single record-memory read port walks all PAGES
// records one per cycle to find the swap offset. A release that hits reads the
// frame's record before it responds; a release that misses goes straight to
// the response. A new request is taken only while the sequencer is idle; a
// finished response waits in the output register and does not hold off the
// next request. The record memory needs no clearing pass after reset.
module frame_allocator_fifo_evict #(
   parameter int PAGES     = 32,
   parameter int PAGE_SIZE = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fafe_pkg::ACTION_W-1:0]       req_action,
   input  logic [fafe_pkg::PAGE_W-1:0]         req_virtual_page,
   input  logic [fafe_pkg::OWNER_W-1:0]        req_owner,
   input  logic signed [fafe_pkg::STACK_W-1:0] req_stack_offset,
   input  logic [fafe_pkg::FRAME_W-1:0]        req_frame_to_clear,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fafe_pkg::FRAME_W-1:0]        rsp_frame,
   output logic                                rsp_evicted,
   output logic [fafe_pkg::PAGE_W-1:0]         rsp_victim_page,
   output logic [fafe_pkg::OWNER_W-1:0]        rsp_victim_owner,
   output logic [fafe_pkg::SWAP_W-1:0]         rsp_swap_offset,
   output logic                                rsp_release_ok,
   output logic [fafe_pkg::FREE_W-1:0]         rsp_free_frames
);
   import fafe_pkg::*;

   localparam int IDX_W  = $clog2(PAGES);
   localparam int CNT_W  = $clog2(PAGES + 1);
   localparam int PS_W   = $clog2(PAGE_SIZE + 1);
   localparam int PROD_W = PAGE_W + PS_W;
   localparam int REC_W  = $bits(rec_type);

   // Sequencer and bookkeeping state
   state_type           state_ff, state_in;
   logic [PAGES-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    addr_ff;
   logic                pend_ff;

   // Captured request and working registers
   logic [ACTION_W-1:0] act_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [OWNER_W-1:0]  owner_ff;
   logic [STACK_W-1:0]  stack_ff;
   logic [IDX_W-1:0]    tgt_ff;
   logic                evict_ff;
   logic                ok_ff;
   logic [PAGE_W-1:0]   res_page_ff;
   logic [OWNER_W-1:0]  res_owner_ff;
   logic [SWAP_W-1:0]   swap_ff;

   // Record memory
   logic [REC_W-1:0]    rec_mem [PAGES];
   logic [REC_W-1:0]    rd_data_ff;
   rec_type             rd_rec;
   rec_type             wr_rec;
   logic                mem_re;
   logic [IDX_W-1:0]    rd_addr;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]  rsp_frame_ff;
   logic                rsp_evicted_ff;
   logic [PAGE_W-1:0]   rsp_page_ff;
   logic [OWNER_W-1:0]  rsp_owner_ff;
   logic [SWAP_W-1:0]   rsp_swap_ff;
   logic                rsp_ok_ff;
   logic [FREE_W-1:0]   rsp_free_ff;

   logic                accept;
   logic                commit;
   logic                clear_in_range;
   logic                clear_hit;
   logic [IDX_W-1:0]    clear_idx;
   logic [IDX_W-1:0]    victim_idx;
   logic                scan_match;
   logic [PROD_W-1:0]   page_prod;

   assign accept         = req_valid && !req_stall;
   assign clear_in_range = 32'(req_frame_to_clear) < PAGES;
   assign clear_idx      = IDX_W'(req_frame_to_clear);
   assign clear_hit      = clear_in_range && valid_ff[clear_idx];
   assign victim_idx     = (ptr_ff >= CNT_W'(PAGES)) ? '0 : IDX_W'(ptr_ff);
   assign rd_rec         = rec_type'(rd_data_ff);
   assign scan_match     = pend_ff && (rd_rec.page == res_page_ff) &&
                           (rd_rec.stack != NO_STACK);
   assign page_prod      = PROD_W'(rd_rec.page) * PROD_W'(PAGE_SIZE);

   always_comb begin
      wr_rec.page  = page_ff;
      wr_rec.owner = owner_ff;
      wr_rec.stack = stack_ff;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_ALLOC) begin
                  state_in = (cnt_ff != '0) ? ST_FIND : ST_READ;
               end else begin
                  state_in = clear_hit ? ST_READ : ST_RESP;
               end
            end
         end
         ST_FIND: begin
            if (!valid_ff[tgt_ff]) begin
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            state_in = evict_ff ? ST_SCAN : ST_RESP;
         end
         ST_SCAN: begin
            if (addr_ff == CNT_W'(PAGES) && !pend_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      mem_re    = 1'b0;
      rd_addr   = tgt_ff;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_READ: begin
            mem_re = 1'b1;
         end
         ST_SCAN: begin
            mem_re  = addr_ff < CNT_W'(PAGES);
            rd_addr = IDX_W'(addr_ff);
         end
         ST_RESP: begin
            commit = !rsp_valid_ff || !rsp_stall;
         end
         ST_FIND, ST_LATCH: begin
            req_stall = 1'b1;
         end
         default: req_stall = 1'b1;
      endcase
   end

   // Update frame map, free count and replacement pointer at commit
   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      if (commit) begin
         if (act_ff == ACT_ALLOC) begin
            valid_in[tgt_ff] = 1'b1;
            if (evict_ff) begin
               ptr_in = CNT_W'(tgt_ff) + CNT_W'(1);
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end else if (ok_ff) begin
            valid_in[tgt_ff] = 1'b0;
            cnt_in           = cnt_ff + CNT_W'(1);
         end
      end
   end

   assign rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         cnt_ff       <= CNT_W'(PAGES);
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         addr_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= (state_ff == ST_SCAN) && mem_re;
         if (state_ff == ST_LATCH) begin
            addr_ff <= '0;
         end else if (state_ff == ST_SCAN && mem_re) begin
            addr_ff <= addr_ff + CNT_W'(1);
         end
      end
   end

   // Working registers: capture, search, victim read and offset scan
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_ff   <= req_action;
               page_ff  <= req_virtual_page;
               owner_ff <= req_owner;
               stack_ff <= req_stack_offset;
               if (req_action == ACT_ALLOC) begin
                  evict_ff <= (cnt_ff == '0);
                  ok_ff    <= 1'b0;
                  tgt_ff   <= (cnt_ff != '0) ? '0 : victim_idx;
               end else begin
                  evict_ff <= 1'b0;
                  ok_ff    <= clear_hit;
                  tgt_ff   <= clear_idx;
               end
            end
         end
         ST_FIND: begin
            if (valid_ff[tgt_ff]) begin
               tgt_ff <= tgt_ff + IDX_W'(1);
            end
         end
         ST_LATCH: begin
            res_page_ff  <= rd_rec.page;
            res_owner_ff <= rd_rec.owner;
            swap_ff      <= SWAP_W'(page_prod);
         end
         ST_SCAN: begin
            if (scan_match) begin
               swap_ff <= rd_rec.stack[SWAP_W-1:0];
            end
         end
         ST_READ, ST_RESP: begin
            act_ff <= act_ff;
         end
         default: act_ff <= act_ff;
      endcase
   end

   // Record memory: write the new record at commit, registered read
   always_ff @(posedge clock) begin
      if (commit && act_ff == ACT_ALLOC) begin
         rec_mem[tgt_ff] <= REC_W'(wr_rec);
      end
      if (mem_re) begin
         rd_data_ff <= rec_mem[rd_addr];
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_frame_ff   <= (act_ff == ACT_ALLOC) ? FRAME_W'(tgt_ff) : '0;
         rsp_evicted_ff <= evict_ff;
         rsp_page_ff    <= (evict_ff || ok_ff) ? res_page_ff : '0;
         rsp_owner_ff   <= (evict_ff || ok_ff) ? res_owner_ff : '0;
         rsp_swap_ff    <= evict_ff ? swap_ff : '0;
         rsp_ok_ff      <= ok_ff;
         rsp_free_ff    <= FREE_W'(cnt_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame        = rsp_frame_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_victim_page  = rsp_page_ff;
   assign rsp_victim_owner = rsp_owner_ff;
   assign rsp_swap_offset  = rsp_swap_ff;
   assign rsp_release_ok   = rsp_ok_ff;
   assign rsp_free_frames  = rsp_free_ff;

   // Free count tracks the frame map
   a_count_matches_map: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) + 32'($countones(valid_ff)) == PAGES)
      else $error("free count out of step with frame map");

   // Eviction commits only with every frame in use
   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      (commit && evict_ff) |-> (&valid_ff))
      else $error("eviction with a free frame present");

   // Free-frame search runs only while some frame is free
   a_find_has_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND) |-> (cnt_ff != '0))
      else $error("free-frame search with no free frame");

   // A successful release frees an allocated frame
   a_release_hits: assert property (@(posedge clock) disable iff (reset)
      (commit && ok_ff) |-> valid_ff[tgt_ff])
      else $error("release of a frame that is not allocated");

endmodule
